>>> rtl/tmsr_pkg.sv
// Package for the tile map scanline renderer core.
// Holds the command and register codes, store sizes and the tile size decode.
// No dependencies.
package tmsr_pkg;

  localparam int MAP_DEPTH    = 65536;
  localparam int TILE_DEPTH   = 262144;
  localparam int SCREEN_WIDTH = 640;

  // Store depths are powers of two: the address wrap is a part-select.
  localparam int MAP_AW  = $clog2(MAP_DEPTH);
  localparam int TILE_AW = $clog2(TILE_DEPTH);

  localparam logic [1:0] CMD_WR_MAP  = 2'd0;
  localparam logic [1:0] CMD_WR_TILE = 2'd1;
  localparam logic [1:0] CMD_RENDER  = 2'd2;

  localparam logic [2:0] REG_MAP_W  = 3'd0;
  localparam logic [2:0] REG_MAP_H  = 3'd1;
  localparam logic [2:0] REG_TSIZE  = 3'd2;
  localparam logic [2:0] REG_POS_X  = 3'd3;
  localparam logic [2:0] REG_POS_Y  = 3'd4;
  localparam logic [2:0] REG_SHOWN  = 3'd5;

  // Remainder steps: |offset| < 4096 and modulus >= 8 keep the quotient below 512.
  localparam int NSTEP = 9;

  typedef struct packed {
    logic        v;
    logic [1:0]  cmd;
    logic [17:0] addr;
    logic [7:0]  value;
    logic        ok;
    logic        ny;
    logic        nx;
    logic [11:0] ry;
    logic [11:0] rx;
  } div_stage_t;

  // log2 of the tile edge; the unused code acts as 16 pixels
  function automatic logic [2:0] tile_shift(input logic [1:0] code);
    logic [2:0] s;
    case (code)
      2'd1:    s = 3'd5;
      2'd2:    s = 3'd3;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/tilemap_scanline_renderer_core.sv
// Tile map background layer renderer, top level.
// Depends on tmsr_pkg for codes, store sizes and the tile size decode.
//
// Takes one transaction per clock while the output is not stalled and returns one pixel per
// render command; the path runs through the entry register, the nine pipelined remainder
// steps that fold the line and column offsets into the map, the fold stage, the map
// multiply, the map store read and the tile store read. Store writes travel down the same
// pipeline and land in order with renders. A stall on the output holds the whole
// pipeline.
module tilemap_scanline_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [17:0] addr,
  input  logic [7:0]  value,
  input  logic [9:0]  screen_line,
  input  logic [9:0]  screen_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel,
  output logic        write_enable,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import tmsr_pkg::*;

  logic [11:0] map_w, map_h;
  logic [1:0]  tsize;
  logic [11:0] pos_x, pos_y;
  logic [16:0] shown;

  logic        adv;
  logic [2:0]  sh;
  logic [16:0] mod_y, mod_x;

  div_stage_t  dv [NSTEP+1];
  div_stage_t  d0;

  logic signed [12:0] dy, dx;
  logic signed [18:0] span_hi;
  logic               in_span;

  logic        f_v, f_ok;
  logic [1:0]  f_cmd;
  logic [17:0] f_addr;
  logic [7:0]  f_value;
  logic [16:0] f_row, f_col;

  logic              m_v, m_ok;
  logic [1:0]        m_cmd;
  logic [17:0]       m_addr;
  logic [7:0]        m_value;
  logic [MAP_AW-1:0] m_maddr;
  logic [4:0]        m_rlow, m_clow;
  logic [24:0]       maddr_full;
  logic [23:0]       m_addr_ext;

  logic        t_v, t_ok;
  logic [1:0]  t_cmd;
  logic [17:0] t_addr;
  logic [7:0]  t_value;
  logic [4:0]  t_rlow, t_clow;
  logic [7:0]  t_idx;
  logic [TILE_AW-1:0] taddr;
  logic [23:0]        taddr_full;
  logic [23:0]        t_addr_ext;

  logic       o_we;
  logic [7:0] o_data;

  logic [7:0] map_mem  [MAP_DEPTH];
  logic [7:0] tile_mem [TILE_DEPTH];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign sh       = tile_shift(tsize);
  assign mod_y    = 17'({5'b0, map_h} << sh);
  assign mod_x    = 17'({5'b0, map_w} << sh);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      map_w <= 12'd1;
      map_h <= 12'd1;
      tsize <= 2'd0;
      pos_x <= 12'd0;
      pos_y <= 12'd0;
      shown <= 17'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_W: map_w <= cfg_data[11:0];
        REG_MAP_H: map_h <= cfg_data[11:0];
        REG_TSIZE: tsize <= cfg_data[1:0];
        REG_POS_X: pos_x <= cfg_data[11:0];
        REG_POS_Y: pos_y <= cfg_data[11:0];
        REG_SHOWN: shown <= cfg_data;
        default:   ;
      endcase
    end
  end

  // entry: offsets, signs and drawn span
  always_comb begin
    dy      = $signed({3'b0, screen_line}) - $signed({pos_y[11], pos_y});
    dx      = $signed({3'b0, screen_column}) - $signed({pos_x[11], pos_x});
    span_hi = $signed({{7{pos_x[11]}}, pos_x}) + $signed({2'b0, shown});
    in_span = !dx[12] && ($signed({9'b0, screen_column}) < span_hi) &&
              ({1'b0, screen_column} < 11'(SCREEN_WIDTH));
    d0.v     = in_valid;
    d0.cmd   = cmd;
    d0.addr  = addr;
    d0.value = value;
    d0.ok    = in_span && (map_w != 12'd0) && (map_h != 12'd0);
    d0.ny    = dy[12];
    d0.nx    = dx[12];
    d0.ry    = dy[12] ? 12'(-dy) : dy[11:0];
    d0.rx    = dx[12] ? 12'(-dx) : dx[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0].v <= 1'b0;
    else if (adv) dv[0] <= d0;
  end

  // restoring remainder, one quotient bit per stage, both axes side by side
  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    localparam logic [4:0] K = 5'(NSTEP - 1 - i);
    logic [24:0] thr_y, thr_x;
    div_stage_t  nxt;
    always_comb begin
      thr_y = {13'b0, map_h} << (5'(sh) + K);
      thr_x = {13'b0, map_w} << (5'(sh) + K);
      nxt   = dv[i];
      if ({13'b0, dv[i].ry} >= thr_y) nxt.ry = dv[i].ry - thr_y[11:0];
      if ({13'b0, dv[i].rx} >= thr_x) nxt.rx = dv[i].rx - thr_x[11:0];
    end
    always_ff @(posedge clk) begin
      if (rst) dv[i+1].v <= 1'b0;
      else if (adv) dv[i+1] <= nxt;
    end
  end

  // fold negative offsets back into the map
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v     <= dv[NSTEP].v;
      f_cmd   <= dv[NSTEP].cmd;
      f_addr  <= dv[NSTEP].addr;
      f_value <= dv[NSTEP].value;
      f_ok    <= dv[NSTEP].ok;
      f_row   <= (dv[NSTEP].ny && dv[NSTEP].ry != 12'd0) ?
                 mod_y - {5'b0, dv[NSTEP].ry} : {5'b0, dv[NSTEP].ry};
      f_col   <= (dv[NSTEP].nx && dv[NSTEP].rx != 12'd0) ?
                 mod_x - {5'b0, dv[NSTEP].rx} : {5'b0, dv[NSTEP].rx};
    end
  end

  // map address
  assign maddr_full = {13'b0, 12'(f_row >> sh)} * {13'b0, map_w} +
                      {13'b0, 12'(f_col >> sh)};
  assign m_addr_ext = {6'b0, f_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v     <= f_v;
      m_cmd   <= f_cmd;
      m_addr  <= f_addr;
      m_value <= f_value;
      m_ok    <= f_ok;
      m_maddr <= (f_cmd == CMD_WR_MAP) ? m_addr_ext[MAP_AW-1:0] : maddr_full[MAP_AW-1:0];
      m_rlow  <= 5'(f_row & ((17'd1 << sh) - 17'd1));
      m_clow  <= 5'(f_col & ((17'd1 << sh) - 17'd1));
    end
  end

  // map store: write or read at this stage only
  always_ff @(posedge clk) begin
    if (adv) begin
      if (m_v && m_cmd == CMD_WR_MAP) map_mem[m_maddr] <= m_value;
      t_idx <= map_mem[m_maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (adv) begin
      t_v     <= m_v;
      t_cmd   <= m_cmd;
      t_addr  <= m_addr;
      t_value <= m_value;
      t_ok    <= m_ok;
      t_rlow  <= m_rlow;
      t_clow  <= m_clow;
    end
  end

  // tile address: ((idx-1)*ts + row%ts)*ts + col%ts
  assign taddr_full = ({16'b0, t_idx - 8'd1} << {sh, 1'b0}) +
                      ({19'b0, t_rlow} << sh) + {19'b0, t_clow};
  assign t_addr_ext = {6'b0, t_addr};
  assign taddr = (t_cmd == CMD_WR_TILE) ? t_addr_ext[TILE_AW-1:0] : taddr_full[TILE_AW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (t_v && t_cmd == CMD_WR_TILE) tile_mem[taddr] <= t_value;
      o_data <= tile_mem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t_v && t_cmd == CMD_RENDER;
    end
    if (adv) o_we <= t_ok && t_idx != 8'd0;
  end

  assign write_enable = o_we;
  assign pixel        = o_we ? o_data : 8'd0;

  // a stall holds the map stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(m_v) && $stable(m_maddr))
    else $error("map stage moved during stall");

  // no result right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a drawn pixel comes only from a render that was in span
  a_draw: assert property (@(posedge clk) disable iff (rst)
    (adv && t_v && t_cmd == CMD_RENDER && !t_ok) |=> !write_enable)
    else $error("pixel drawn outside span");

endmodule

>>> verif/tmsr_pixel_checker.sv
// Pixel checker for the tile map scanline renderer core.
// Mirrors the stores and registers, predicts each rendered pixel and compares results.
// Depends on tmsr_pkg for command, register codes and store depths.
`timescale 1ns / 1ps
module tmsr_pixel_checker
  import tmsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [17:0] addr,
  input  logic [7:0]  value,
  input  logic [9:0]  screen_line,
  input  logic [9:0]  screen_column,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  pixel,
  input  logic        write_enable,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [7:0] pixel;
    logic       write_enable;
  } shaded_t;

  logic [7:0]  map_mem [MAP_DEPTH];
  logic [7:0]  tile_mem [TILE_DEPTH];
  logic [11:0] map_w, map_h, pos_x, pos_y;
  logic [1:0]  tsize;
  logic [16:0] shown;
  shaded_t     due_pixels[$];
  int          fails;

  function automatic longint wrap_mod(input longint a, input longint m);
    longint r;
    r = a % m;
    return (r < 0) ? r + m : r;
  endfunction

  function automatic shaded_t shade_pixel(input logic [9:0] ln, input logic [9:0] cl);
    shaded_t r;
    longint  ts, px, py, lo, hi, row, mc, maddr, taddr;
    logic [7:0] idx;
    r.pixel = 8'd0;
    r.write_enable = 1'b0;
    case (tsize)
      2'd1:    ts = 32;
      2'd2:    ts = 8;
      default: ts = 16;
    endcase
    px = longint'($signed(pos_x));
    py = longint'($signed(pos_y));
    lo = (px > 0) ? px : 0;
    hi = px + longint'(shown);
    if (hi > SCREEN_WIDTH) hi = SCREEN_WIDTH;
    if (map_w != 0 && map_h != 0 && longint'(cl) >= lo && longint'(cl) < hi) begin
      row = wrap_mod(longint'(ln) - py, longint'(map_h) * ts);
      mc = wrap_mod(longint'(cl) - px, longint'(map_w) * ts);
      maddr = ((row / ts) * longint'(map_w) + mc / ts) % MAP_DEPTH;
      idx = map_mem[MAP_AW'(maddr)];
      if (idx != 0) begin
        taddr = ((longint'(idx) - 1) * ts + row % ts) * ts + mc % ts;
        r.pixel = tile_mem[TILE_AW'(taddr % TILE_DEPTH)];
        r.write_enable = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    shaded_t want;
    if (rst) begin
      map_w = 12'd1;
      map_h = 12'd1;
      tsize = 2'd0;
      pos_x = 12'd0;
      pos_y = 12'd0;
      shown = 17'd0;
      due_pixels.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_W: map_w = cfg_data[11:0];
          REG_MAP_H: map_h = cfg_data[11:0];
          REG_TSIZE: tsize = cfg_data[1:0];
          REG_POS_X: pos_x = cfg_data[11:0];
          REG_POS_Y: pos_y = cfg_data[11:0];
          REG_SHOWN: shown = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          $error("unexpected transaction: pixel %0d write_enable %0b", pixel, write_enable);
          fails++;
        end else begin
          want = due_pixels.pop_front();
          if (pixel !== want.pixel) begin
            $error("pixel: expected %0d, actual %0d", want.pixel, pixel);
            fails++;
          end
          if (write_enable !== want.write_enable) begin
            $error("write_enable: expected %0b, actual %0b", want.write_enable, write_enable);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (cmd)
          CMD_WR_MAP:  map_mem[addr[MAP_AW-1:0]] = value;
          CMD_WR_TILE: tile_mem[addr[TILE_AW-1:0]] = value;
          CMD_RENDER:  due_pixels.push_back(shade_pixel(screen_line, screen_column));
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending <= due_pixels.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the tile map scanline renderer testbench: clock, reset, stimulus and verdict.
// Depends on tmsr_pkg, tilemap_scanline_renderer_core and tmsr_pixel_checker.
`timescale 1ns / 1ps
module testbench;
  import tmsr_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [17:0] addr;
  logic [7:0]  value;
  logic [9:0]  screen_line;
  logic [9:0]  screen_column;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel;
  logic        write_enable;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;
  int          fail_count;
  int          pending;

  // settings and store contents as the stimulus has set them
  logic [11:0] map_w, map_h, pos_x, pos_y;
  logic [1:0]  tsize;
  logic [16:0] shown;
  logic [7:0]  map_seen [MAP_DEPTH];
  bit          map_set [MAP_DEPTH];
  bit          tile_set [TILE_DEPTH];
  bit          calm;
  int          quiet_cycles;

  tilemap_scanline_renderer_core u_dut (.*);

  tmsr_pixel_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output stall: runs of stall and release, none in calm phases
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(0, 99);
        n = (n < 70) ? $urandom_range(1, 2) : (n < 95) ? $urandom_range(3, 6)
                                                        : $urandom_range(20, 40);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send(input logic [1:0] c, input logic [17:0] a, input logic [7:0] v,
                      input logic [9:0] ln, input logic [9:0] cl);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    addr <= a;
    value <= v;
    screen_line <= ln;
    screen_column <= cl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_map(input logic [17:0] a, input logic [7:0] v);
    map_seen[a[MAP_AW-1:0]] = v;
    map_set[a[MAP_AW-1:0]] = 1'b1;
    send(CMD_WR_MAP, a, v, 10'($urandom), 10'($urandom));
  endtask

  task automatic write_tile(input logic [17:0] a, input logic [7:0] v);
    tile_set[a[TILE_AW-1:0]] = 1'b1;
    send(CMD_WR_TILE, a, v, 10'($urandom), 10'($urandom));
  endtask

  // Fill the map and tile entries that this pixel reads, if not yet written, then render.
  task automatic render(input logic [9:0] ln, input logic [9:0] cl);
    longint ts, px, py, lo, hi, row, mc, maddr, taddr;
    logic [7:0] idx;
    case (tsize)
      2'd1:    ts = 32;
      2'd2:    ts = 8;
      default: ts = 16;
    endcase
    px = longint'($signed(pos_x));
    py = longint'($signed(pos_y));
    lo = (px > 0) ? px : 0;
    hi = px + longint'(shown);
    if (hi > SCREEN_WIDTH) hi = SCREEN_WIDTH;
    if (map_w != 0 && map_h != 0 && longint'(cl) >= lo && longint'(cl) < hi) begin
      row = (longint'(ln) - py) % (longint'(map_h) * ts);
      if (row < 0) row += longint'(map_h) * ts;
      mc = (longint'(cl) - px) % (longint'(map_w) * ts);
      if (mc < 0) mc += longint'(map_w) * ts;
      maddr = ((row / ts) * longint'(map_w) + mc / ts) % MAP_DEPTH;
      if (!map_set[MAP_AW'(maddr)])
        write_map({2'($urandom), 16'(maddr)},
                  ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      idx = map_seen[MAP_AW'(maddr)];
      if (idx != 0) begin
        taddr = (((longint'(idx) - 1) * ts + row % ts) * ts + mc % ts) % TILE_DEPTH;
        if (!tile_set[TILE_AW'(taddr)]) write_tile(18'(taddr), 8'($urandom));
      end
    end
    send(CMD_RENDER, 18'($urandom), 8'($urandom), ln, cl);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // writes cause no result: let them leave the pipeline
    repeat (20) @(posedge clk);
  endtask

  task automatic set_layer(input logic [11:0] w, input logic [11:0] h, input logic [1:0] code,
                           input logic [11:0] px, input logic [11:0] py,
                           input logic [16:0] sw);
    logic [16:0] vals [6];
    vals = '{17'(w), 17'(h), 17'(code), 17'(px), 17'(py), sw};
    map_w = w;
    map_h = h;
    tsize = code;
    pos_x = px;
    pos_y = py;
    shown = sw;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int r;
    longint lo, hi;
    logic [11:0] w, h, px;
    logic [16:0] sw;
    r = $urandom_range(0, 9);
    w = (r < 6) ? 12'($urandom_range(1, 6)) : (r < 9) ? 12'($urandom_range(1, 4095)) : 12'd0;
    r = $urandom_range(0, 9);
    h = (r < 6) ? 12'($urandom_range(1, 6)) : (r < 9) ? 12'($urandom_range(1, 4095)) : 12'd0;
    px = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 128) - 64) : 12'($urandom);
    r = $urandom_range(0, 9);
    sw = (r < 6) ? 17'($urandom_range(100, 700)) : (r < 8) ? 17'($urandom) :
         17'($urandom_range(0, 40));
    set_layer(w, h, 2'($urandom), px, 12'($urandom), sw);
    lo = ($signed(px) > 0) ? longint'($signed(px)) : 0;
    hi = longint'($signed(px)) + longint'(sw);
    if (hi > SCREEN_WIDTH) hi = SCREEN_WIDTH;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45 && hi > lo)
        render(10'($urandom), 10'($urandom_range(int'(lo), int'(hi) - 1)));
      else if (r < 65)
        render(10'($urandom), 10'($urandom));
      else if (r < 78)
        write_map(($urandom_range(0, 1) == 1) ? 18'($urandom_range(0, 255)) : 18'($urandom),
                  8'($urandom));
      else if (r < 94)
        write_tile(18'($urandom), 8'($urandom));
      else
        send(2'd3, 18'($urandom), 8'($urandom), 10'($urandom), 10'($urandom));
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_WR_MAP;
    addr <= '0;
    value <= '0;
    screen_line <= '0;
    screen_column <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAP_W;
    cfg_data <= '0;
    calm = 1'b0;
    map_w = 12'd1;
    map_h = 12'd1;
    tsize = 2'd0;
    pos_x = 12'd0;
    pos_y = 12'd0;
    shown = 17'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one-tile map, transparent index, store wrap, span edges, unused command
    set_layer(12'd1, 12'd1, 2'd2, 12'd0, 12'd0, 17'd640);
    write_map(18'd0, 8'd0);
    render(10'd0, 10'd0);
    write_map(18'h3ffff, 8'd255);
    write_tile(18'h3ffff, 8'd0);
    write_tile(18'd0, 8'd255);
    write_map(18'h10000, 8'd1);
    render(10'd0, 10'd0);
    render(10'd1023, 10'd639);
    render(10'd7, 10'd640);
    render(10'd5, 10'd1023);
    send(2'd3, 18'h3ffff, 8'hff, 10'h3ff, 10'h3ff);
    drain();
    set_layer(12'd4095, 12'd4095, 2'd1, 12'h800, 12'h7ff, 17'h1ffff);
    render(10'd0, 10'd0);
    render(10'd1023, 10'd639);
    render(10'd500, 10'd1023);
    drain();
    set_layer(12'd0, 12'd3, 2'd3, 12'h7ff, 12'hff9, 17'd0);
    render(10'd0, 10'd0);
    render(10'd10, 10'd700);
    drain();
    set_layer(12'd3, 12'd0, 2'd0, 12'd100, 12'd0, 17'd200);
    render(10'd3, 10'd150);
    drain();

    for (int p = 0; p < 9; p++) begin
      calm = (p % 3 == 2);
      random_phase(70);
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
